// File: sv/tcb_pkg.sv
// Shared types and constants for the text console cell buffer.
// No dependencies; used by every module of the block but the checker.

package tcb_pkg;

  // Default geometry of the cell store
  localparam int ROWS_DEF = 256;
  localparam int COLS_DEF = 128;

  // Control characters
  localparam logic [7:0] CH_NUL       = 8'd0;
  localparam logic [7:0] CH_BACKSPACE = 8'd8;
  localparam logic [7:0] CH_NEWLINE   = 8'd10;
  localparam logic [7:0] CH_RETURN    = 8'd13;

  // Operation codes carried on in_tuser
  localparam logic OP_PUT  = 1'b0;
  localparam logic OP_READ = 1'b1;

  // Configuration register indexes and reset values
  localparam logic REG_VIS_COLS = 1'b0;
  localparam logic REG_VIS_ROWS = 1'b1;
  localparam logic [7:0] VIS_COLS_RST = 8'd100;
  localparam logic [8:0] VIS_ROWS_RST = 9'd37;

  localparam int IN_DATA_W  = 32;
  localparam int OUT_DATA_W = 40;

  // Class of an accepted beat, decided in the front
  typedef enum logic [2:0] {
    K_NOP,
    K_PRINT,
    K_NEWLINE,
    K_BACKSPACE,
    K_READ
  } kind_t;

  // One queued item
  typedef struct packed {
    kind_t       kind;
    logic [7:0]  chr;
    logic [1:0]  color;
    logic [7:0]  rd_row;
    logic [6:0]  rd_col;
  } item_t;

  // Configuration seen by the back end
  typedef struct packed {
    logic [7:0] vis_cols;
    logic [8:0] vis_rows;
  } cfg_t;

endpackage

// File: sv/tcb_cfg.sv
// APB-style register file for the visible window size.
// Depends on tcb_pkg for register indexes, reset values and cfg_t.

module tcb_cfg (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             psel,
  input  logic             penable,
  input  logic             pwrite,
  input  logic [2:0]       paddr,
  input  logic [31:0]      pwdata,
  output logic [31:0]      prdata,
  output logic             pready,
  output tcb_pkg::cfg_t    cfg
);

  logic [7:0] vis_cols_r;
  logic [8:0] vis_rows_r;
  logic       wr_en;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite && pready;

  // Register writes; the word select is address bit 2
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vis_cols_r <= tcb_pkg::VIS_COLS_RST;
      vis_rows_r <= tcb_pkg::VIS_ROWS_RST;
    end else if (wr_en) begin
      if (paddr[2] == tcb_pkg::REG_VIS_COLS) begin
        vis_cols_r <= pwdata[7:0];
      end else begin
        vis_rows_r <= pwdata[8:0];
      end
    end
  end

  // Read back
  always_comb begin
    if (paddr[2] == tcb_pkg::REG_VIS_ROWS) begin
      prdata = {23'd0, vis_rows_r};
    end else begin
      prdata = {24'd0, vis_cols_r};
    end
  end

  assign cfg.vis_cols = vis_cols_r;
  assign cfg.vis_rows = vis_rows_r;

endmodule

// File: sv/tcb_front.sv
// Front end: accepts input beats, classifies them and queues them.
// Depends on tcb_pkg for kind_t and item_t.

module tcb_front (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_valid,
  output logic                           in_ready,
  input  logic                           in_user,
  input  logic [tcb_pkg::IN_DATA_W-1:0]  in_data,
  output logic                           q_valid,
  input  logic                           q_pop,
  output tcb_pkg::item_t                 q_item
);

  tcb_pkg::item_t queue_r [2];
  logic           wp_r;
  logic           rp_r;
  logic [1:0]     cnt_r;
  logic [1:0]     cnt_nxt;
  logic           push;
  tcb_pkg::item_t ent;

  // Classify the incoming beat
  always_comb begin
    ent.chr    = in_data[7:0];
    ent.color  = in_data[9:8];
    ent.rd_row = in_data[17:10];
    ent.rd_col = in_data[24:18];
    if (in_user == tcb_pkg::OP_READ) begin
      ent.kind = tcb_pkg::K_READ;
    end else begin
      case (in_data[7:0])
        tcb_pkg::CH_NUL:       ent.kind = tcb_pkg::K_NOP;
        tcb_pkg::CH_RETURN:    ent.kind = tcb_pkg::K_NOP;
        tcb_pkg::CH_NEWLINE:   ent.kind = tcb_pkg::K_NEWLINE;
        tcb_pkg::CH_BACKSPACE: ent.kind = tcb_pkg::K_BACKSPACE;
        default:               ent.kind = tcb_pkg::K_PRINT;
      endcase
    end
  end

  assign in_ready = (cnt_r != 2'd2);
  assign push     = in_valid && in_ready;
  assign q_valid  = (cnt_r != 2'd0);
  assign q_item   = queue_r[rp_r];

  always_comb begin
    cnt_nxt = cnt_r;
    if (push && !q_pop) begin
      cnt_nxt = cnt_r + 2'd1;
    end else if (!push && q_pop) begin
      cnt_nxt = cnt_r - 2'd1;
    end
  end

  // Two-entry queue pointers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= 1'b0;
      rp_r  <= 1'b0;
      cnt_r <= 2'd0;
    end else begin
      cnt_r <= cnt_nxt;
      if (push) begin
        wp_r <= ~wp_r;
      end
      if (q_pop) begin
        rp_r <= ~rp_r;
      end
    end
  end

  // Queue storage
  always_ff @(posedge clk) begin
    if (push) begin
      queue_r[wp_r] <= ent;
    end
  end

endmodule

// File: sv/tcb_back.sv
// Back end: cursor and scroll state, cell and row-length stores, result register.
// Depends on tcb_pkg for item_t, cfg_t and kind codes.

module tcb_back #(
  parameter int ROWS = tcb_pkg::ROWS_DEF,
  parameter int COLS = tcb_pkg::COLS_DEF
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  tcb_pkg::cfg_t                   cfg,
  input  logic                            q_valid,
  output logic                            q_pop,
  input  tcb_pkg::item_t                  q_item,
  output logic                            out_valid,
  input  logic                            out_ready,
  output logic [tcb_pkg::OUT_DATA_W-1:0]  out_data
);

  localparam int RW  = $clog2(ROWS);
  localparam int CW  = $clog2(COLS + 1);
  localparam int CIW = $clog2(COLS);
  localparam int AW  = $clog2(ROWS * COLS);
  localparam int VCW = (CW > 8) ? CW : 8;
  localparam int VRW = ((RW > 9) ? RW : 9) + 1;
  localparam int RRW = ((RW > 8) ? RW : 8) + 1;
  localparam int LCW = (CW > 7) ? CW : 7;
  localparam logic [RW-1:0] LAST_ROW = RW'(ROWS - 1);

  // Architectural state
  logic [RW-1:0] cur_row_r, cur_row_nxt;
  logic [CW-1:0] cur_col_r, cur_col_nxt;
  logic [RW-1:0] view_top_r, view_top_nxt;
  logic [RW-1:0] base_r, base_nxt;
  logic [RW-1:0] cur_phys_r, cur_phys_nxt;
  logic          row0_wr_r, row0_wr_nxt;

  // Stores
  logic [9:0]    cell_mem [ROWS*COLS];
  logic [CW-1:0] len_mem  [ROWS];
  logic [9:0]    cell_q_r;
  logic [CW-1:0] len_q_r;

  // Result register
  logic          r_valid_r;
  logic [RW-1:0] r_row_r;
  logic [CW-1:0] r_col_r;
  logic [RW-1:0] r_vt_r;
  logic          r_scr_r;
  logic          r_rd_r;
  logic          r_inr_r;
  logic [6:0]    r_rc_r;
  logic          r_mem_r;
  logic [CW-1:0] r_bylen_r;

  logic          adv, fire;
  logic          is_print, is_nl, is_bs, is_rd;
  logic [VCW-1:0] vcols_eff, col_x;
  logic [8:0]    vrows_eff;
  logic          wrap, open_row, last_row, scroll;
  logic [RW-1:0] row_o, vt_a, phys_o;
  logic [VRW-1:0] row_o_x, vt_x, vr_x;
  logic [CW-1:0] col_base;
  logic          len_we, cell_we;
  logic [AW-1:0] cell_waddr, cell_raddr;
  logic [RRW-1:0] rr_x;
  logic          rd_inr;
  logic [RW-1:0] rr_t;
  logic [RW:0]   rsum;
  logic [RW-1:0] phys_r;
  logic          rd_byp, rd_zero;
  logic [CW-1:0] len_sel;
  logic          present;
  logic [9:0]    cell_out;

  assign adv   = !r_valid_r || out_ready;
  assign fire  = q_valid && adv;
  assign q_pop = fire;

  assign is_print = (q_item.kind == tcb_pkg::K_PRINT);
  assign is_nl    = (q_item.kind == tcb_pkg::K_NEWLINE);
  assign is_bs    = (q_item.kind == tcb_pkg::K_BACKSPACE);
  assign is_rd    = (q_item.kind == tcb_pkg::K_READ);

  // Effective window size
  always_comb begin
    if (cfg.vis_cols == 8'd0 || VCW'(cfg.vis_cols) > VCW'(COLS)) begin
      vcols_eff = VCW'(COLS);
    end else begin
      vcols_eff = VCW'(cfg.vis_cols);
    end
    vrows_eff = (cfg.vis_rows == 9'd0) ? 9'd1 : cfg.vis_rows;
  end

  assign col_x    = VCW'(cur_col_r);
  assign wrap     = (col_x >= vcols_eff);
  assign open_row = is_nl || (is_print && wrap);
  assign last_row = (cur_row_r == LAST_ROW);
  assign scroll   = open_row && last_row;

  // Put path: new row, scroll and view tracking
  always_comb begin
    row_o  = cur_row_r;
    phys_o = cur_phys_r;
    if (open_row) begin
      if (!last_row) begin
        row_o = cur_row_r + RW'(1);
      end
      phys_o = (cur_phys_r == LAST_ROW) ? '0 : cur_phys_r + RW'(1);
    end
    vt_a = view_top_r;
    if (scroll && view_top_r != '0) begin
      vt_a = view_top_r - RW'(1);
    end
    row_o_x = VRW'(row_o);
    vt_x    = VRW'(vt_a);
    vr_x    = VRW'(vrows_eff);
  end

  always_comb begin
    cur_row_nxt  = cur_row_r;
    cur_col_nxt  = cur_col_r;
    view_top_nxt = view_top_r;
    base_nxt     = base_r;
    cur_phys_nxt = cur_phys_r;
    col_base     = open_row ? '0 : cur_col_r;
    len_we       = 1'b0;
    cell_we      = 1'b0;
    if (open_row) begin
      cur_row_nxt  = row_o;
      cur_phys_nxt = phys_o;
      cur_col_nxt  = '0;
      len_we       = 1'b1;
      if (row_o_x >= vt_x + vr_x) begin
        view_top_nxt = RW'(row_o_x + VRW'(1) - vr_x);
      end else begin
        view_top_nxt = vt_a;
      end
      if (scroll) begin
        base_nxt = (base_r == LAST_ROW) ? '0 : base_r + RW'(1);
      end
    end
    if (is_print) begin
      cur_col_nxt = col_base + CW'(1);
      len_we      = 1'b1;
      cell_we     = 1'b1;
    end
    if (is_bs && cur_col_r != '0) begin
      cur_col_nxt = cur_col_r - CW'(1);
      len_we      = 1'b1;
    end
  end

  assign row0_wr_nxt = row0_wr_r || (len_we && phys_o == '0);
  assign cell_waddr  = AW'(phys_o) * AW'(COLS) + AW'(col_base[CIW-1:0]);

  // Read path: physical row and length source
  always_comb begin
    rr_x   = RRW'(q_item.rd_row);
    rd_inr = (rr_x < RRW'(ROWS));
    rr_t   = RW'(q_item.rd_row);
    rsum   = {1'b0, base_r} + {1'b0, rr_t};
    if (rsum >= (RW+1)'(ROWS)) begin
      phys_r = RW'(rsum - (RW+1)'(ROWS));
    end else begin
      phys_r = rsum[RW-1:0];
    end
    rd_byp  = (rr_t == cur_row_r);
    rd_zero = (rr_t > cur_row_r) || (phys_r == '0 && !row0_wr_r);
  end

  assign cell_raddr = AW'(phys_r) * AW'(COLS) + AW'(CIW'(q_item.rd_col));

  // Control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cur_row_r  <= '0;
      cur_col_r  <= '0;
      view_top_r <= '0;
      base_r     <= '0;
      cur_phys_r <= '0;
      row0_wr_r  <= 1'b0;
      r_valid_r  <= 1'b0;
    end else begin
      if (fire) begin
        cur_row_r  <= cur_row_nxt;
        cur_col_r  <= cur_col_nxt;
        view_top_r <= view_top_nxt;
        base_r     <= base_nxt;
        cur_phys_r <= cur_phys_nxt;
        row0_wr_r  <= row0_wr_nxt;
      end
      if (adv) begin
        r_valid_r <= fire;
      end
    end
  end

  // Result payload
  always_ff @(posedge clk) begin
    if (fire) begin
      r_row_r   <= cur_row_nxt;
      r_col_r   <= cur_col_nxt;
      r_vt_r    <= view_top_nxt;
      r_scr_r   <= scroll;
      r_rd_r    <= is_rd;
      r_inr_r   <= rd_inr;
      r_rc_r    <= q_item.rd_col;
      r_mem_r   <= !rd_byp && !rd_zero;
      r_bylen_r <= rd_byp ? cur_col_r : '0;
    end
  end

  // Cell store: one write or one read per beat
  always_ff @(posedge clk) begin
    if (fire && cell_we) begin
      cell_mem[cell_waddr] <= {q_item.color, q_item.chr};
    end
    if (fire && is_rd) begin
      cell_q_r <= cell_mem[cell_raddr];
    end
  end

  // Row length store
  always_ff @(posedge clk) begin
    if (fire && len_we) begin
      len_mem[phys_o] <= cur_col_nxt;
    end
    if (fire && is_rd) begin
      len_q_r <= len_mem[phys_r];
    end
  end

  // Result assembly
  assign len_sel  = r_mem_r ? len_q_r : r_bylen_r;
  assign present  = r_rd_r && r_inr_r && (LCW'(r_rc_r) < LCW'(len_sel));
  assign cell_out = present ? cell_q_r : 10'd0;

  assign out_valid = r_valid_r;
  assign out_data  = {4'd0, present, cell_out[9:8], cell_out[7:0],
                      r_scr_r && !r_rd_r, 8'(r_vt_r), 8'(r_col_r), 8'(r_row_r)};

endmodule

// File: sv/text_console_cell_buffer.sv
// Path: the two-entry queue decouples input and result sides; a beat passes it, then the
// result register, which out_tready can stall. Throughput: one beat per cycle while
// out_tready is high; each beat makes at most one cell-store and one row-length access.
// Reset: cursor, view top, row base, queue and result register clear at once; the
// cell store is not cleared, row lengths follow from the cursor, so no clearing pass.
// Depends on tcb_pkg, tcb_cfg, tcb_front, tcb_back.

module text_console_cell_buffer #(
  parameter int ROWS = tcb_pkg::ROWS_DEF,
  parameter int COLS = tcb_pkg::COLS_DEF
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_tvalid,
  output logic                            in_tready,
  // operation
  input  logic                            in_tuser,
  // char_code[7:0], color_index[9:8], read_row[17:10], read_col[24:18], zero pad
  input  logic [tcb_pkg::IN_DATA_W-1:0]   in_tdata,
  output logic                            out_tvalid,
  input  logic                            out_tready,
  // cursor_row_out[7:0], cursor_col_out[15:8], view_top_out[23:16], scrolled[24],
  // cell_char[32:25], cell_color[34:33], cell_present[35], zero pad
  output logic [tcb_pkg::OUT_DATA_W-1:0]  out_tdata,
  input  logic                            cfg_psel,
  input  logic                            cfg_penable,
  input  logic                            cfg_pwrite,
  input  logic [2:0]                      cfg_paddr,
  input  logic [31:0]                     cfg_pwdata,
  output logic [31:0]                     cfg_prdata,
  output logic                            cfg_pready
);

  tcb_pkg::cfg_t  cfg;
  tcb_pkg::item_t q_item;
  logic           q_valid;
  logic           q_pop;

  tcb_cfg u_cfg (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (cfg_psel),
    .penable (cfg_penable),
    .pwrite  (cfg_pwrite),
    .paddr   (cfg_paddr),
    .pwdata  (cfg_pwdata),
    .prdata  (cfg_prdata),
    .pready  (cfg_pready),
    .cfg     (cfg)
  );

  tcb_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_tvalid),
    .in_ready (in_tready),
    .in_user  (in_tuser),
    .in_data  (in_tdata),
    .q_valid  (q_valid),
    .q_pop    (q_pop),
    .q_item   (q_item)
  );

  tcb_back #(
    .ROWS (ROWS),
    .COLS (COLS)
  ) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (cfg),
    .q_valid   (q_valid),
    .q_pop     (q_pop),
    .q_item    (q_item),
    .out_valid (out_tvalid),
    .out_ready (out_tready),
    .out_data  (out_tdata)
  );

endmodule

// File: sv/tcb_checker.sv
// Port-level checks for the text console cell buffer, bound to the top level.
// Depends on text_console_cell_buffer's port list and parameters only.

module tcb_checker #(
  parameter int ROWS = 256,
  parameter int COLS = 128
) (
  input logic        clk,
  input logic        rst_n,
  input logic        out_tvalid,
  input logic        out_tready,
  input logic [39:0] out_tdata
);

  // Stalled result beat holds
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("result beat changed while stalled");

  // Nothing comes out right after reset
  a_rst: assert property (@(posedge clk) rst_n && $past(!rst_n) |-> !out_tvalid)
    else $error("result valid right after reset");

  // An absent cell reads as zero
  a_absent: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tdata[35] |-> out_tdata[34:25] == 10'd0)
    else $error("absent cell with nonzero fields");

  // A scroll leaves the cursor on the last row and carries no cell
  a_scroll: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tdata[24] |-> out_tdata[7:0] == 8'(ROWS - 1) && !out_tdata[35])
    else $error("scroll with cursor off the last row");

  // Cursor column never passes the row width
  a_col: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> (COLS > 255) || (out_tdata[15:8] <= 8'(COLS)))
    else $error("cursor column beyond row width");

endmodule

bind text_console_cell_buffer tcb_checker #(.ROWS(ROWS), .COLS(COLS)) u_tcb_checker (.*);
